/* sv/open_addressing_hash_set_assert.svh */
// Assertion macros for the hash set block.
`ifndef OPEN_ADDRESSING_HASH_SET_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_SET_ASSERT_SVH
`ifndef SYNTH
`define OAHS_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define OAHS_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define OAHS_ASSERT_IMP(lbl, a, c, msg)
`define OAHS_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

/* sv/oahs_pkg.sv */
package oahs_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_DELETED = 2'd1;
  localparam logic [1:0] ST_FILLED = 2'd2;
  localparam int KEY_W = 64;
  localparam int LEN_W = 4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } cmd_t;
endpackage

/* sv/oahs_front.sv */
// Saturates length, masks unused key bytes, two-entry queue toward the back end.
module oahs_front #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode,
  input  logic [63:0] key_bytes,
  input  logic [3:0] key_length,
  output logic q_valid,
  input  logic q_take,
  output oahs_pkg::cmd_t q_cmd
);
  oahs_pkg::cmd_t buf0, buf1, cls;
  logic [1:0] cnt;
  logic [3:0] slen;
  logic acc;

  always_comb begin
    slen = (key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : key_length;
    cls.opcode = opcode;
    cls.len = slen;
    for (int b = 0; b < 8; b++) begin
      cls.key[8*b +: 8] = (4'(b) < slen) ? key_bytes[8*b +: 8] : 8'h00;
    end
  end

  assign in_stall = (cnt == 2'd2);
  assign acc = in_valid && !in_stall;
  assign q_valid = (cnt != 2'd0);
  assign q_cmd = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(acc) - 2'(q_take);
    end
    if (q_take) begin
      buf0 <= buf1;
      if (acc && cnt == 2'd1) buf0 <= cls;
      if (acc && cnt == 2'd2) buf1 <= cls;
    end else if (acc) begin
      if (cnt == 2'd0) buf0 <= cls;
      else buf1 <= cls;
    end
  end
endmodule

/* sv/oahs_back.sv */
// Executes one command at a time: byte-serial hash, serial modulo, probe loop,
// and growth rehash through a scratch copy of the table.
module oahs_back #(
  parameter int MAX_SLOTS = 256,
  parameter int INITIAL_SLOTS = 8,
  localparam int AW = $clog2(MAX_SLOTS),
  localparam int CW = AW + 1
) (
  input  logic clk,
  input  logic rst,
  input  logic [15:0] mult,
  input  logic q_valid,
  output logic q_take,
  input  oahs_pkg::cmd_t q_cmd,
  output logic res_valid,
  input  logic res_stall,
  output logic ok,
  output logic busy
);
  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_HASH  = 12'b000000000010,
    S_MOD   = 12'b000000000100,
    S_RD    = 12'b000000001000,
    S_CHK   = 12'b000000010000,
    S_DONE  = 12'b000000100000,
    S_OUT   = 12'b000001000000,
    S_CPY   = 12'b000010000000,
    S_GSCAN = 12'b000100000000,
    S_GCHK  = 12'b001000000000,
    S_CLR   = 12'b010000000000,
    S_GPRB  = 12'b100000000000
  } state_t;

  state_t state;
  logic [63:0] key_mem [MAX_SLOTS];
  logic [3:0] len_mem [MAX_SLOTS];
  logic [1:0] st_mem [MAX_SLOTS];
  logic [63:0] tkey_mem [MAX_SLOTS];
  logic [3:0] tlen_mem [MAX_SLOTS];
  logic tfil_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] st_vld;

  oahs_pkg::cmd_t cmd;
  logic [63:0] h, hprod, rkey, tkey;
  logic [3:0] rlen, tlen, bidx;
  logic [1:0] rst_st;
  logic rvld;
  logic rfil;
  logic [6:0] mbit;
  logic [CW-1:0] rem, cap, pos, tgt, step, scan;
  logic [CW-1:0] cnt;
  logic have_del, have_tgt, res_ok, rehash;
  logic [CW+1:0] lhs, rhs;

  always_comb begin
    hprod = h * {48'd0, mult};
  end

  logic [CW:0] remsh;
  always_comb begin
    remsh = {rem, h[mbit[5:0]]};
  end

  logic [CW:0] pn;
  always_comb begin
    pn = {1'b0, pos} + {1'b0, step} + (CW+1)'(1);
    if (pn >= {1'b0, cap}) pn = pn - {1'b0, cap};
  end

  wire [1:0] rstat = rvld ? rst_st : oahs_pkg::ST_EMPTY;
  wire same = (rstat == oahs_pkg::ST_FILLED) && rlen == cmd.len && rkey == cmd.key;
  assign lhs = ((CW+2)'(cnt) + (CW+2)'(1)) << 2;
  assign rhs = (CW+2)'(cap) * (CW+2)'(3);
  wire over = lhs > rhs;
  wire can_grow = ({1'b0, cap} << 1) <= (CW+1)'(MAX_SLOTS);

  assign q_take = (state == S_IDLE) && q_valid;
  assign res_valid = (state == S_OUT);
  assign ok = res_ok;
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    rkey <= key_mem[pos[AW-1:0]];
    rlen <= len_mem[pos[AW-1:0]];
    rst_st <= st_mem[pos[AW-1:0]];
    rvld <= st_vld[pos[AW-1:0]];
    tkey <= tkey_mem[scan[AW-1:0]];
    tlen <= tlen_mem[scan[AW-1:0]];
    rfil <= tfil_mem[scan[AW-1:0]];
    if (rst) begin
      state <= S_IDLE;
      st_vld <= '0;
      cnt <= '0;
      cap <= CW'(INITIAL_SLOTS);
      res_ok <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (q_valid) begin
          cmd <= q_cmd;
          h <= '0;
          bidx <= '0;
          rehash <= 1'b0;
          state <= S_HASH;
        end
        S_HASH: begin
          if (bidx == cmd.len) begin
            rem <= '0;
            mbit <= 7'd63;
            state <= S_MOD;
          end else begin
            h <= hprod + {56'd0, cmd.key[8*bidx[2:0] +: 8]};
            bidx <= bidx + 4'd1;
          end
        end
        S_MOD: begin
          rem <= (remsh >= {1'b0, cap}) ? CW'(remsh - {1'b0, cap}) : remsh[CW-1:0];
          if (mbit == 7'd0) state <= S_RD;
          else mbit <= mbit - 7'd1;
          step <= '0;
          have_del <= 1'b0;
          have_tgt <= 1'b0;
        end
        S_RD: begin
          if (mbit == 7'd0 && step == '0 && !have_del && !have_tgt) pos <= rem;
          state <= S_CHK;
          mbit <= 7'd1;
        end
        S_CHK: begin
          if (mbit != 7'd0) begin
            mbit <= 7'd0;
          end else if (rehash) begin
            if (rstat == oahs_pkg::ST_EMPTY) begin
              key_mem[pos[AW-1:0]] <= tkey;
              len_mem[pos[AW-1:0]] <= tlen;
              st_mem[pos[AW-1:0]] <= oahs_pkg::ST_FILLED;
              st_vld[pos[AW-1:0]] <= 1'b1;
              scan <= scan + CW'(1);
              state <= S_GSCAN;
            end else begin
              pos <= pn[CW-1:0];
              step <= step + CW'(1);
              state <= S_RD;
              mbit <= 7'd1;
            end
          end else if (cmd.opcode == oahs_pkg::OP_INSERT) begin
            if (same) begin
              res_ok <= 1'b0;
              state <= S_OUT;
            end else begin
              if (!have_del && rstat == oahs_pkg::ST_DELETED) begin
                have_del <= 1'b1;
                have_tgt <= 1'b1;
                tgt <= pos;
              end
              if (rstat == oahs_pkg::ST_EMPTY || step == cap - CW'(1)) begin
                if (rstat == oahs_pkg::ST_EMPTY && !have_del) begin
                  tgt <= pos;
                  have_tgt <= 1'b1;
                end
                state <= S_DONE;
              end else begin
                pos <= pn[CW-1:0];
                step <= step + CW'(1);
                state <= S_RD;
                mbit <= 7'd1;
              end
            end
          end else if (cmd.opcode == oahs_pkg::OP_DELETE ||
                       cmd.opcode == oahs_pkg::OP_LOOKUP) begin
            if (same) begin
              res_ok <= 1'b1;
              if (cmd.opcode == oahs_pkg::OP_DELETE) begin
                st_mem[pos[AW-1:0]] <= oahs_pkg::ST_DELETED;
                cnt <= cnt - CW'(1);
              end
              state <= S_OUT;
            end else if (rstat == oahs_pkg::ST_EMPTY || step == cap - CW'(1)) begin
              res_ok <= 1'b0;
              state <= S_OUT;
            end else begin
              pos <= pn[CW-1:0];
              step <= step + CW'(1);
              state <= S_RD;
              mbit <= 7'd1;
            end
          end else begin
            res_ok <= 1'b0;
            state <= S_OUT;
          end
        end
        S_DONE: begin
          if ((over && !can_grow) || !have_tgt) begin
            res_ok <= 1'b0;
            state <= S_OUT;
          end else begin
            key_mem[tgt[AW-1:0]] <= cmd.key;
            len_mem[tgt[AW-1:0]] <= cmd.len;
            st_mem[tgt[AW-1:0]] <= oahs_pkg::ST_FILLED;
            st_vld[tgt[AW-1:0]] <= 1'b1;
            cnt <= cnt + CW'(1);
            res_ok <= 1'b1;
            scan <= '0;
            pos <= '0;
            mbit <= 7'd1;
            state <= over ? S_CPY : S_OUT;
          end
        end
        S_CPY: begin
          // copy old table into scratch, one slot a cycle; read data is registered
          // and arrives in the cycle after its address
          pos <= pos + CW'(1);
          if (mbit != 7'd0) begin
            mbit <= 7'd0;
          end else begin
            tkey_mem[scan[AW-1:0]] <= rkey;
            tlen_mem[scan[AW-1:0]] <= rlen;
            tfil_mem[scan[AW-1:0]] <= (rstat == oahs_pkg::ST_FILLED);
            if (scan == cap - CW'(1)) begin
              state <= S_CLR;
            end else begin
              scan <= scan + CW'(1);
            end
          end
        end
        S_CLR: begin
          st_vld <= '0;
          scan <= '0;
          rehash <= 1'b1;
          state <= S_GSCAN;
        end
        S_GSCAN: begin
          if (scan == cap) begin
            cap <= cap << 1;
            state <= S_OUT;
          end else begin
            state <= S_GCHK;
          end
        end
        S_GCHK: state <= S_GPRB;
        S_GPRB: begin
          if (!rfil) begin
            scan <= scan + CW'(1);
            state <= S_GSCAN;
          end else begin
            cmd.key <= tkey;
            cmd.len <= tlen;
            h <= '0;
            bidx <= '0;
            cap <= cap << 1;
            state <= S_HASH;
          end
        end
        S_OUT: if (!res_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      // during rehash cap is doubled while hashing one entry, restored after place
      if (state == S_CHK && mbit == 7'd0 && rehash && rstat == oahs_pkg::ST_EMPTY)
        cap <= cap >> 1;
    end
  end
endmodule

/* sv/open_addressing_hash_set.sv */
// Hash set with quadratic (triangular) probing, one operation per item, one ok
// result per item, one item at a time. An item is taken, hashed byte by byte,
// reduced by a bit-serial modulo and probed slot by slot, a read and a check
// per slot, with one more step for an insert; the result is held until the
// receiver takes it. An insert that pushes the load past 3/4 also rebuilds a
// table of twice the size, or fails if that would exceed MAX_SLOTS: each old
// slot is copied to scratch, then each stored key is hashed and placed anew.
// The hash multiplier may be written only while the block is idle.
module open_addressing_hash_set #(
  parameter int MAX_SLOTS = 256,
  parameter int INITIAL_SLOTS = 8,
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] opcode,
  input  logic [63:0] key_bytes,
  input  logic [3:0] key_length,
  output logic out_valid,
  input  logic out_stall,
  output logic ok,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_data
);
`include "open_addressing_hash_set_assert.svh"
  logic [15:0] hash_multiplier;
  logic q_valid, q_take, busy;
  oahs_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) hash_multiplier <= 16'd71;
    else if (cfg_valid && cfg_ready) hash_multiplier <= cfg_data;
  end

  oahs_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
    .clk, .rst, .in_valid, .in_stall, .opcode, .key_bytes, .key_length,
    .q_valid, .q_take, .q_cmd
  );

  oahs_back #(.MAX_SLOTS(MAX_SLOTS), .INITIAL_SLOTS(INITIAL_SLOTS)) u_back (
    .clk, .rst, .mult(hash_multiplier), .q_valid, .q_take, .q_cmd,
    .res_valid(out_valid), .res_stall(out_stall), .ok, .busy
  );

  `OAHS_ASSERT_IMP(a_take_idle, q_take, q_valid && !busy, "take without queued item")
  `OAHS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok), "result dropped")
  `OAHS_ASSERT_NXT(a_take_busy, q_take, busy, "back end not started")
endmodule

/* sim/open_addressing_hash_set_test.sv */
module open_addressing_hash_set_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS_MAX = 256;
  localparam int SLOTS_INIT = 8;
  localparam int KEY_MAX = 8;
  localparam int IDLE_LIMIT = 200000;
  localparam logic [1:0] OP_BAD = 2'd3;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] opcode;
  logic [63:0] key_bytes;
  logic [3:0] key_length;
  logic out_valid, out_stall, ok;
  logic cfg_valid, cfg_ready;
  logic [15:0] cfg_data;

  open_addressing_hash_set u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .key_bytes(key_bytes), .key_length(key_length),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] mult;
  logic [63:0] tbl_key [SLOTS_MAX];
  logic [3:0] tbl_len [SLOTS_MAX];
  logic [1:0] tbl_st [SLOTS_MAX];
  logic [1:0] tmp_st [SLOTS_MAX];
  logic [63:0] tmp_key [SLOTS_MAX];
  logic [3:0] tmp_len [SLOTS_MAX];
  int unsigned fill_count, cap;

  logic expected_ok [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;

  typedef struct {
    logic [1:0] op;
    logic [63:0] key;
    logic [3:0] len;
    int want;  // -1: from predictor
  } row_t;

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int unsigned home(logic [63:0] k, int unsigned n, int unsigned c);
    logic [63:0] h;
    h = 0;
    for (int b = 0; b < n; b++) h = h * {48'd0, mult} + {56'd0, k[8*b +: 8]};
    return int'(h % c);
  endfunction

  function automatic int unsigned find_slot(logic [63:0] k, int unsigned n);
    int unsigned p;
    p = home(k, n, cap);
    for (int unsigned i = 0; i < cap; i++) begin
      if (tbl_st[p] == oahs_pkg::ST_EMPTY) break;
      if (tbl_st[p] == oahs_pkg::ST_FILLED && tbl_len[p] == n && tbl_key[p] == k) return p;
      p = (p + i + 1) % cap;
    end
    return cap;
  endfunction

  function automatic void rebuild();
    int unsigned old, p;
    old = cap;
    tmp_st = tbl_st;
    tmp_key = tbl_key;
    tmp_len = tbl_len;
    foreach (tbl_st[s]) tbl_st[s] = oahs_pkg::ST_EMPTY;
    cap = old * 2;
    for (int unsigned s = 0; s < old; s++) begin
      if (tmp_st[s] != oahs_pkg::ST_FILLED) continue;
      p = home(tmp_key[s], tmp_len[s], cap);
      for (int unsigned i = 0; i < cap; i++) begin
        if (tbl_st[p] == oahs_pkg::ST_EMPTY) begin
          tbl_key[p] = tmp_key[s];
          tbl_len[p] = tmp_len[s];
          tbl_st[p] = oahs_pkg::ST_FILLED;
          break;
        end
        p = (p + i + 1) % cap;
      end
    end
  endfunction

  function automatic bit try_insert(logic [63:0] k, int unsigned n);
    int unsigned p, tgt;
    bit seen_del, over;
    p = home(k, n, cap);
    tgt = cap;
    seen_del = 0;
    for (int unsigned i = 0; i < cap; i++) begin
      if (tbl_st[p] == oahs_pkg::ST_FILLED && tbl_len[p] == n && tbl_key[p] == k) return 0;
      if (!seen_del && tbl_st[p] == oahs_pkg::ST_DELETED) begin
        seen_del = 1;
        tgt = p;
      end
      if (tbl_st[p] == oahs_pkg::ST_EMPTY) begin
        if (!seen_del) tgt = p;
        break;
      end
      p = (p + i + 1) % cap;
    end
    over = (fill_count + 1) * 4 > cap * 3;
    if (over && cap * 2 > SLOTS_MAX) return 0;
    if (tgt >= cap) return 0;
    tbl_key[tgt] = k;
    tbl_len[tgt] = n[3:0];
    tbl_st[tgt] = oahs_pkg::ST_FILLED;
    fill_count++;
    if (over) rebuild();
    return 1;
  endfunction

  function automatic bit predict_ok(logic [1:0] op, logic [63:0] k, logic [3:0] l);
    int unsigned n, s;
    n = (l > KEY_MAX) ? KEY_MAX : l;
    if (n < 8) k = k & ((64'd1 << (8 * n)) - 64'd1);
    case (op)
      oahs_pkg::OP_INSERT: return try_insert(k, n);
      oahs_pkg::OP_DELETE: begin
        s = find_slot(k, n);
        if (s < cap) begin
          tbl_st[s] = oahs_pkg::ST_DELETED;
          fill_count--;
          return 1;
        end
        return 0;
      end
      oahs_pkg::OP_LOOKUP: return find_slot(k, n) < cap;
      default: return 0;
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: stall pattern plus commanded long hold-off
  initial begin
    out_stall = 1;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_off) out_stall <= 1;
      else case ($urandom_range(0, 3))
        0: out_stall <= ($urandom_range(0, 1) == 0);
        1: out_stall <= ($urandom_range(0, 7) == 0);
        default: out_stall <= 0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_ok.size() == 0) report("result with nothing expected");
      else begin
        logic e;
        e = expected_ok.pop_front();
        if (ok !== e) report($sformatf("ok got %b want %b", ok, e));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("open_addressing_hash_set regression: fail");
      $finish;
    end
  end

  // hand one item to the block; checks against table or predictor
  task automatic send(logic [1:0] op, logic [63:0] k, logic [3:0] l, int want);
    bit p;
    opcode <= op;
    key_bytes <= k;
    key_length <= l;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    p = predict_ok(op, k, l);
    if (want >= 0 && p != want[0]) report("directed row disagrees with predictor");
    expected_ok.push_back(want >= 0 ? want[0] : p);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_ok.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_mult(logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    mult = v;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // keys mostly from a small pool so deletes and lookups hit
  logic [63:0] pool_key [32];
  logic [3:0] pool_len [32];

  task automatic random_phase(int count, int pool_n);
    int gap, burst;
    logic [1:0] op;
    int pick;
    logic [3:0] l;
    logic [63:0] k;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        in_valid <= 0;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) @(posedge clk);
        burst = $urandom_range(1, 20);
      end
      burst--;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = oahs_pkg::OP_INSERT;
        4, 5: op = oahs_pkg::OP_DELETE;
        9: op = ($urandom_range(0, 3) == 0) ? OP_BAD : oahs_pkg::OP_LOOKUP;
        default: op = oahs_pkg::OP_LOOKUP;
      endcase
      if ($urandom_range(0, 7) != 0) begin
        pick = $urandom_range(0, pool_n - 1);
        k = pool_key[pick];
        l = pool_len[pick];
        // junk above the length must not matter
        if (l < 8 && $urandom_range(0, 1)) k = k | (rand_key() << (8 * l));
      end else begin
        k = rand_key();
        l = 4'($urandom_range(0, 15));
      end
      send(op, k, l, -1);
    end
  endtask

  row_t dir [$];

  initial begin
    rst = 1;
    in_valid = 0;
    opcode = oahs_pkg::OP_INSERT;
    key_bytes = 0;
    key_length = 0;
    cfg_valid = 0;
    cfg_data = 0;
    mult = 16'd71;
    fill_count = 0;
    cap = SLOTS_INIT;
    foreach (tbl_st[s]) tbl_st[s] = oahs_pkg::ST_EMPTY;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    dir = '{
      '{oahs_pkg::OP_LOOKUP, 64'h0, 4'd0, 0},
      '{oahs_pkg::OP_INSERT, 64'h0, 4'd0, 1},
      '{oahs_pkg::OP_INSERT, 64'hFF, 4'd0, 0},
      '{oahs_pkg::OP_LOOKUP, 64'h0, 4'd0, 1},
      '{oahs_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1},
      '{oahs_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1},
      '{oahs_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 0},
      '{oahs_pkg::OP_INSERT, 64'hAA55_0061, 4'd1, 1},
      '{oahs_pkg::OP_LOOKUP, 64'h61, 4'd1, 1},
      '{oahs_pkg::OP_DELETE, 64'h61, 4'd1, 1},
      '{oahs_pkg::OP_DELETE, 64'h61, 4'd1, 0},
      '{oahs_pkg::OP_LOOKUP, 64'h61, 4'd1, 0},
      '{oahs_pkg::OP_INSERT, 64'h6261, 4'd2, -1},
      '{oahs_pkg::OP_INSERT, 64'h61, 4'd1, 1},
      '{OP_BAD, 64'h61, 4'd1, 0},
      '{oahs_pkg::OP_INSERT, 64'h1, 4'd1, -1},
      '{oahs_pkg::OP_INSERT, 64'h2, 4'd1, -1},
      '{oahs_pkg::OP_INSERT, 64'h3, 4'd1, -1},
      '{oahs_pkg::OP_INSERT, 64'h4, 4'd1, -1},
      '{oahs_pkg::OP_INSERT, 64'h5, 4'd1, -1},
      '{oahs_pkg::OP_LOOKUP, 64'h3, 4'd1, -1},
      '{oahs_pkg::OP_DELETE, 64'h0, 4'd0, 1},
      '{oahs_pkg::OP_LOOKUP, 64'h5555_AAAA_0F0F_F0F0, 4'd8, 0}
    };
    foreach (dir[i]) send(dir[i].op, dir[i].key, dir[i].len, dir[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      int pool_n;
      case (ph)
        0: write_mult(16'd1);
        1: write_mult(16'hFFFF);
        2: write_mult(16'd0);
        3: write_mult(16'd71);
        default: write_mult(16'($urandom_range(1, 65535)));
      endcase
      pool_n = (ph == 5) ? 32 : $urandom_range(4, 32);
      foreach (pool_key[j]) begin
        pool_key[j] = rand_key();
        pool_len[j] = 4'($urandom_range(0, 8));
      end
      if (ph == 2) begin
        // fill with fresh keys while receiver holds off
        hold_off = 1;
        fork
          begin repeat (400) @(posedge clk); hold_off = 0; end
          random_phase(40, pool_n);
        join
      end
      random_phase((ph == 5) ? 400 : 180, pool_n);
      drain();
    end
    // push toward the growth limit with mostly fresh inserts
    for (int i = 0; i < 320; i++)
      send(($urandom_range(0, 9) == 0) ? oahs_pkg::OP_LOOKUP : oahs_pkg::OP_INSERT,
           rand_key(), 4'($urandom_range(1, 8)), -1);
    drain();

    if (errors == 0) $display("open_addressing_hash_set regression: pass");
    else $display("open_addressing_hash_set regression: fail");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+sv
sv/oahs_pkg.sv
sv/oahs_front.sv
sv/oahs_back.sv
sv/open_addressing_hash_set.sv
sim/open_addressing_hash_set_test.sv
